// ----- hdl/brm_pkg.sv -----
// Shared types and constants of the banked ROM mapper.
`timescale 1ns / 1ps
`default_nettype none
package brm_pkg;

    // Field widths of the bus words
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int BANK_W = 8;
    localparam int ROM_W  = 21;

    // Bus access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Result kinds
    localparam logic KIND_ROM = 1'b0;
    localparam logic KIND_FWD = 1'b1;

    // Writes above this address are dropped when forwarding is off
    localparam logic [ADDR_W-1:0] IGNORE_ABOVE = 16'hB000;

    // Register map
    localparam int                 CFG_ADDR_W       = 3;
    localparam int                 CFG_DATA_W       = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_FORWARD_ADDR = 3'd0;
    localparam logic               FORWARD_RESET    = 1'b1;

    // Request word
    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } req_word_t;

    // Response word
    typedef struct packed {
        logic              result_kind;
        logic [ROM_W-1:0]  rom_address;
        logic [ADDR_W-1:0] forwarded_address;
        logic [DATA_W-1:0] forwarded_data;
    } rsp_word_t;

    // Bank register write request
    typedef struct packed {
        logic              en;
        logic [BANK_W-1:0] bank;
    } bank_wr_t;

endpackage
`default_nettype wire

// ----- hdl/brm_cfg_regs.sv -----
// Configuration register block of the banked ROM mapper (APB-style port).
`timescale 1ns / 1ps
`default_nettype none
module brm_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [brm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [brm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [brm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output logic                                  forward_writes
);

    logic forward_reg;
    logic forward_next;
    logic wr_hit;

    // No wait states
    assign pready = 1'b1;

    // Register write decode
    assign wr_hit = psel && penable && pwrite && pready
                    && (paddr == brm_pkg::REG_FORWARD_ADDR);

    always_comb
    begin
        forward_next = forward_reg;
        if (wr_hit)
        begin
            forward_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forward_reg <= brm_pkg::FORWARD_RESET;
        end
        else
        begin
            forward_reg <= forward_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (paddr == brm_pkg::REG_FORWARD_ADDR)
        begin
            prdata[0] = forward_reg;
        end
    end

    assign forward_writes = forward_reg;

endmodule
`default_nettype wire

// ----- hdl/brm_bank_file.sv -----
// Per-page bank registers with a combinational lookup and one write port.
`timescale 1ns / 1ps
`default_nettype none
module brm_bank_file #(
    parameter int PAGE_BITS  = 13,
    parameter int PAGE_COUNT = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [brm_pkg::ADDR_W-PAGE_BITS-1:0] page,
    input  wire brm_pkg::bank_wr_t                  wr,
    output logic      [brm_pkg::BANK_W-1:0]         bank
);

    localparam int IDX_W = $clog2(PAGE_COUNT);

    logic [brm_pkg::BANK_W-1:0] bank_reg [PAGE_COUNT];
    logic [IDX_W-1:0]           idx;
    logic                       page_hit;

    // Pages two to five start at index minus two, the rest at their index
    function automatic logic [brm_pkg::BANK_W-1:0] reset_bank(input int i);
        logic [brm_pkg::BANK_W-1:0] val;
        if (i >= 2 && i <= 5)
        begin
            val = brm_pkg::BANK_W'(i - 2);
        end
        else
        begin
            val = brm_pkg::BANK_W'(i);
        end
        return val;
    endfunction

    assign page_hit = (32'(page) < PAGE_COUNT);
    assign idx      = IDX_W'(page);

    // Lookup; pages past the table map to themselves
    assign bank = page_hit ? bank_reg[idx] : brm_pkg::BANK_W'(page);

    // Bank update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAGE_COUNT; i++)
            begin
                bank_reg[i] <= reset_bank(i);
            end
        end
        else if (wr.en && page_hit)
        begin
            bank_reg[idx] <= wr.bank;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/banked_rom_mapper_top.sv -----
// Top level of the banked ROM mapper: request stage, mapping logic, response register.
`timescale 1ns / 1ps
`default_nettype none
// Takes one bus word per clock unless rsp_ready stalls a full response register: a
// word sits in the request register while its page's bank register is looked up (or
// written) and the ROM address is formed, then moves into the response register
// behind rsp_valid. The single bank-lookup stage sets this rate, and a bank write is
// seen by the next word. Reads always answer with a ROM address; writes answer with a
// forwarded word only while forward_writes is set, else writes above 0xB000 are
// dropped. Config must be written only while idle; the block does not enforce it.
module banked_rom_mapper_top #(
    parameter int PAGE_BITS  = 13,
    parameter int PAGE_COUNT = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            req_valid,
    output logic                                 req_ready,
    input  wire brm_pkg::req_word_t              req,
    // response channel
    output logic                                 rsp_valid,
    input  wire logic                            rsp_ready,
    output brm_pkg::rsp_word_t                   rsp,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [brm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [brm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [brm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    localparam int PG_W   = brm_pkg::ADDR_W - PAGE_BITS;
    localparam int FULL_W = brm_pkg::BANK_W + PAGE_BITS;

    logic                  forward_writes;
    logic                  a_valid_reg, a_valid_next;
    brm_pkg::req_word_t    a_word_reg, a_word_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    brm_pkg::rsp_word_t    rsp_word_reg, rsp_word_next, rsp_calc;
    logic [PG_W-1:0]       page;
    logic [PAGE_BITS-1:0]  low;
    logic [brm_pkg::BANK_W-1:0] bank;
    logic [FULL_W-1:0]     rom_full;
    logic                  is_write;
    logic                  ignore_wr;
    logic                  has_result;
    logic                  out_free;
    logic                  a_fire;
    logic                  req_fire;
    brm_pkg::bank_wr_t     bank_wr;

    brm_cfg_regs u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .forward_writes (forward_writes)
    );

    // Decode the staged word
    assign page       = a_word_reg.address[brm_pkg::ADDR_W-1:PAGE_BITS];
    assign low        = a_word_reg.address[PAGE_BITS-1:0];
    assign is_write   = (a_word_reg.operation == brm_pkg::OP_WRITE);
    assign ignore_wr  = !forward_writes && (a_word_reg.address > brm_pkg::IGNORE_ABOVE);
    assign has_result = !is_write || forward_writes;

    // Handshake between stages
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign a_fire    = a_valid_reg && (!has_result || out_free);
    assign req_ready = !a_valid_reg || a_fire;
    assign req_fire  = req_valid && req_ready;

    // Bank write for the staged word
    assign bank_wr.en   = a_fire && is_write && !ignore_wr;
    assign bank_wr.bank = a_word_reg.write_data;

    brm_bank_file #(
        .PAGE_BITS  (PAGE_BITS),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_banks (
        .clk   (clk),
        .rst_n (rst_n),
        .page  (page),
        .wr    (bank_wr),
        .bank  (bank)
    );

    // Mapping: bank concatenated with page offset, cut to ROM width
    assign rom_full = {bank, low};

    always_comb
    begin
        rsp_calc = '0;
        if (is_write)
        begin
            rsp_calc.result_kind       = brm_pkg::KIND_FWD;
            rsp_calc.forwarded_address = a_word_reg.address;
            rsp_calc.forwarded_data    = a_word_reg.write_data;
        end
        else
        begin
            rsp_calc.result_kind = brm_pkg::KIND_ROM;
            rsp_calc.rom_address = brm_pkg::ROM_W'(rom_full);
        end
    end

    // Next-state logic of both stages
    always_comb
    begin
        a_valid_next   = a_valid_reg;
        a_word_next    = a_word_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        if (a_fire)
        begin
            a_valid_next = 1'b0;
        end
        if (req_fire)
        begin
            a_valid_next = 1'b1;
            a_word_next  = req;
        end
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (a_fire && has_result)
        begin
            rsp_valid_next = 1'b1;
            rsp_word_next  = rsp_calc;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_word_reg   <= a_word_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_word_reg;

    // A staged word that owes a response must wait for a free response register
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && has_result && rsp_valid_reg && !rsp_ready) |-> !req_ready)
        else $error("request taken while staged word is blocked");

    // Only writes may leave the stage without a response
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && !has_result) |-> (is_write && !forward_writes))
        else $error("staged word dropped without response");

    // A staged write leaving in forwarding mode is then presented as a forwarded word
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && has_result && is_write) |=>
            (rsp_valid && rsp.result_kind == brm_pkg::KIND_FWD && forward_writes))
        else $error("forwarded word not presented");

endmodule
`default_nettype wire
